// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the capture controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hw/rtl/lctc_pkg.sv
// Shared constants, codes and beat types of the logic capture trigger controller.
package lctc_pkg;

   localparam int CAPTURE_DEPTH = 512;
   localparam int PRE_DEPTH     = 32;
   localparam int CHANNELS      = 32;

   localparam int CAP_AW   = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
   localparam int PRE_AW   = (PRE_DEPTH > 1) ? $clog2(PRE_DEPTH) : 1;
   localparam int WP_W     = $clog2(CAPTURE_DEPTH + 1);
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int PRE_LIMIT = (PRE_DEPTH < CAPTURE_DEPTH) ? PRE_DEPTH : CAPTURE_DEPTH;
   localparam int CLR_DEPTH = (PRE_DEPTH > CAPTURE_DEPTH) ? PRE_DEPTH : CAPTURE_DEPTH;
   localparam int CLR_W    = $clog2(CLR_DEPTH);

   localparam logic [31:0] CHAN_MASK =
      (CHANNELS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << CHANNELS) - 64'd1);

   // item kinds
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_ARM    = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_SOURCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLING_EDGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_SHOT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMATION   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_COUNT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_AVAIL   = 3'd6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] sample_bits;
      logic        ext_level;
      logic [8:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [31:0] read_word;
      logic [9:0]  fill_level;
      logic        frame_started;
      logic        armed_flag;
   } rsp_type;

endpackage

// File: hw/rtl/lctc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lctc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/logic_capture_trigger_controller.sv
// Top level of the logic capture trigger controller.
//
// Usage:
//   req_*  : one item per beat: a sample tick, an arm request or a read of the
//            capture store. rsp_* : exactly one result beat per item, in order.
//   csr_*  : plain register write port, write only while the block is idle.
// Result path and throughput:
//   Sample ticks and arm requests: result registered, seen in the cycle after
//   acceptance; one such item per cycle while rsp_stall does not hold the output.
//   Reads: the result passes the registered read port of the capture RAM, then
//   the output register; no item is taken while a read waits. A sample tick
//   that restarts a frame with n pre-trigger points blocks req while the ring
//   RAM is copied into the capture RAM, one word a cycle through the ring read port.
// Reset:
//   Synchronous, active high. After reset a clearing pass zeroes both RAMs,
//   one entry a cycle; req_stall stays high during it.
// Back-pressure:
//   Results sit in an output register. While rsp_stall holds it full, the
//   register and its payload hold and req_stall rises; an item is taken while
//   the held result drains in the same cycle.
module logic_capture_trigger_controller
   import lctc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

`include "assert_macros.svh"

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;
   localparam logic [1:0] S_COPY  = 2'd3;

   // configuration
   logic [5:0]  trig_src_ff;
   logic        falling_ff;
   logic        one_shot_ff;
   logic [15:0] decim_ff;
   logic [19:0] holdoff_ff;
   logic [5:0]  pre_count_ff;
   logic        trig_avail_ff;

   // control state
   logic [1:0]        state_ff, state_in;
   logic [CLR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [WP_W-1:0]   wp_ff, wp_in;
   logic [19:0]       pw_ff, pw_in;
   logic [PRE_AW-1:0] rp_ff, rp_in;
   logic [15:0]       rc_ff, rc_in;
   logic              prev_ff, prev_in;
   logic              arm_ff, arm_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rd_oob_ff, rd_oob_in;
   logic [5:0]        copy_n_ff, copy_n_in;
   logic [5:0]        copy_rd_ff, copy_rd_in;
   logic [PRE_AW-1:0] copy_ra_ff, copy_ra_in;
   logic              copy_wv_ff, copy_wv_in;
   logic [CAP_AW-1:0] copy_wa_ff, copy_wa_in;

   // datapath
   logic              out_free;
   logic              req_accept;
   logic [31:0]       word;
   logic [15:0]       rc_inc;
   logic              ring_hit;
   logic [PRE_AW-1:0] rp_next;
   logic [19:0]       pw_inc;
   logic              filling;
   logic              cap_hit;
   logic [WP_W-1:0]   wp_fill;
   logic              waiting;
   logic [19:0]       pw_wait;
   logic              lvl;
   logic              hit;
   logic              restart;
   logic [5:0]        n_sat;
   logic [PRE_AW:0]   start_sum;
   logic [PRE_AW-1:0] start_pos;
   logic [PRE_AW-1:0] copy_ra_next;

   // RAM ports
   logic              cap_we, cap_re;
   logic [CAP_AW-1:0] cap_wa, cap_ra;
   logic [31:0]       cap_wd, cap_rd;
   logic              ring_we, ring_re;
   logic [PRE_AW-1:0] ring_wa;
   logic [31:0]       ring_wd, ring_rd;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == S_RUN) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_src_ff   <= 6'd0;
         falling_ff    <= 1'b0;
         one_shot_ff   <= 1'b0;
         decim_ff      <= 16'd1;
         holdoff_ff    <= 20'd4410;
         pre_count_ff  <= 6'd0;
         trig_avail_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRIG_SOURCE:  trig_src_ff   <= csr_wdata[5:0];
            CSR_FALLING_EDGE: falling_ff    <= csr_wdata[0];
            CSR_ONE_SHOT:     one_shot_ff   <= csr_wdata[0];
            CSR_DECIMATION:   decim_ff      <= csr_wdata[15:0];
            CSR_HOLDOFF:      holdoff_ff    <= csr_wdata[19:0];
            CSR_PRE_COUNT:    pre_count_ff  <= csr_wdata[5:0];
            CSR_TRIG_AVAIL:   trig_avail_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sample tick arithmetic
   assign word     = req_data.sample_bits & CHAN_MASK;
   assign rc_inc   = rc_ff + 16'd1;
   assign ring_hit = (rc_inc >= decim_ff);
   assign rp_next  = (rp_ff == PRE_AW'(PRE_DEPTH - 1)) ? '0 : rp_ff + PRE_AW'(1);
   assign pw_inc   = pw_ff + 20'd1;
   assign filling  = (wp_ff < WP_W'(CAPTURE_DEPTH));
   assign cap_hit  = filling && (pw_inc >= {4'd0, decim_ff});
   assign wp_fill  = cap_hit ? wp_ff + WP_W'(1) : wp_ff;
   assign waiting  = (wp_fill >= WP_W'(CAPTURE_DEPTH));
   // a store that just became full had its point count cleared this tick
   assign pw_wait  = filling ? 20'd1 : pw_inc;

   // trigger level and edge
   always_comb begin
      if (32'(trig_src_ff) < CHANNELS) begin
         lvl = word[CH_W'(trig_src_ff)];
      end else begin
         lvl = req_data.ext_level;
      end
      hit = falling_ff ? (prev_ff && !lvl) : (!prev_ff && lvl);
   end

   // saturate the pre-trigger count
   always_comb begin
      if (32'(pre_count_ff) > PRE_LIMIT) begin
         n_sat = 6'(PRE_LIMIT);
      end else begin
         n_sat = pre_count_ff;
      end
   end

   // oldest ring point to copy, counted back from the updated ring position
   assign start_sum = {1'b0, rp_in} + (PRE_AW+1)'(PRE_DEPTH) - (PRE_AW+1)'(n_sat);
   assign start_pos = (start_sum >= (PRE_AW+1)'(PRE_DEPTH))
                      ? PRE_AW'(start_sum - (PRE_AW+1)'(PRE_DEPTH))
                      : PRE_AW'(start_sum);
   assign copy_ra_next = (copy_ra_ff == PRE_AW'(PRE_DEPTH - 1))
                         ? '0 : copy_ra_ff + PRE_AW'(1);

   // item processing and sequencing
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wp_in        = wp_ff;
      pw_in        = pw_ff;
      rp_in        = rp_ff;
      rc_in        = rc_ff;
      prev_in      = prev_ff;
      arm_in       = arm_ff;
      rd_oob_in    = rd_oob_ff;
      copy_n_in    = copy_n_ff;
      copy_rd_in   = copy_rd_ff;
      copy_ra_in   = copy_ra_ff;
      copy_wv_in   = 1'b0;
      copy_wa_in   = copy_wa_ff;
      restart      = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (req_accept) begin
               case (req_data.kind)
                  KIND_ARM: begin
                     arm_in = 1'b1;
                  end
                  KIND_READ: begin
                     rd_oob_in = (32'(req_data.read_index) >= CAPTURE_DEPTH);
                     state_in  = S_READ;
                  end
                  KIND_SAMPLE: begin
                     rc_in = ring_hit ? 16'd0 : rc_inc;
                     rp_in = ring_hit ? rp_next : rp_ff;
                     if (filling) begin
                        pw_in = cap_hit ? 20'd0 : pw_inc;
                     end
                     wp_in = wp_fill;
                     if (waiting) begin
                        if (!trig_avail_ff) begin
                           restart = 1'b1;
                        end else begin
                           pw_in   = pw_wait;
                           prev_in = lvl;
                           if (!one_shot_ff) begin
                              arm_in = 1'b0;
                              if (hit || (pw_wait >= holdoff_ff)) begin
                                 restart = 1'b1;
                              end
                           end else if (arm_ff && hit) begin
                              restart = 1'b1;
                              arm_in  = 1'b0;
                           end
                        end
                     end
                     if (restart) begin
                        pw_in = 20'd0;
                        wp_in = WP_W'(n_sat);
                        if (n_sat != 6'd0) begin
                           state_in   = S_COPY;
                           copy_n_in  = n_sat;
                           copy_rd_in = 6'd0;
                           copy_ra_in = start_pos;
                        end
                     end
                  end
                  default: ;
               endcase
               // reads answer from the RAM's registered read port in S_READ; everything else now
               if (req_data.kind != KIND_READ) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.read_word     = 32'd0;
                  rsp_data_in.fill_level    = 10'(wp_in);
                  rsp_data_in.frame_started = restart;
                  rsp_data_in.armed_flag    = arm_in;
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.read_word     = rd_oob_ff ? 32'd0 : cap_rd;
               rsp_data_in.fill_level    = 10'(wp_ff);
               rsp_data_in.frame_started = 1'b0;
               rsp_data_in.armed_flag    = arm_ff;
               state_in                  = S_RUN;
            end
         end
         S_COPY: begin
            // issue ring reads; each write lands in the cycle after its read
            if (copy_rd_ff != copy_n_ff) begin
               copy_rd_in = copy_rd_ff + 6'd1;
               copy_ra_in = copy_ra_next;
               copy_wv_in = 1'b1;
               copy_wa_in = CAP_AW'(copy_rd_ff);
            end else begin
               state_in = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         pw_ff        <= 20'd0;
         rp_ff        <= '0;
         rc_ff        <= 16'd0;
         prev_ff      <= 1'b0;
         arm_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         copy_wv_ff   <= 1'b0;
         copy_n_ff    <= 6'd0;
         copy_rd_ff   <= 6'd0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         pw_ff        <= pw_in;
         rp_ff        <= rp_in;
         rc_ff        <= rc_in;
         prev_ff      <= prev_in;
         arm_ff       <= arm_in;
         rsp_valid_ff <= rsp_valid_in;
         copy_wv_ff   <= copy_wv_in;
         copy_n_ff    <= copy_n_in;
         copy_rd_ff   <= copy_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_oob_ff   <= rd_oob_in;
      copy_ra_ff  <= copy_ra_in;
      copy_wa_ff  <= copy_wa_in;
   end

   // capture RAM ports
   always_comb begin
      cap_we = 1'b0;
      cap_wa = CAP_AW'(wp_ff);
      cap_wd = word;
      case (state_ff)
         S_CLEAR: begin
            cap_we = (32'(clr_cnt_ff) < CAPTURE_DEPTH);
            cap_wa = CAP_AW'(clr_cnt_ff);
            cap_wd = 32'd0;
         end
         S_RUN: begin
            cap_we = req_accept && (req_data.kind == KIND_SAMPLE) && cap_hit;
         end
         S_COPY: begin
            cap_we = copy_wv_ff;
            cap_wa = copy_wa_ff;
            cap_wd = ring_rd;
         end
         default: ;
      endcase
   end

   assign cap_re = req_accept && (req_data.kind == KIND_READ);
   assign cap_ra = CAP_AW'(req_data.read_index);

   // ring RAM ports
   always_comb begin
      ring_we = 1'b0;
      ring_wa = rp_ff;
      ring_wd = word;
      case (state_ff)
         S_CLEAR: begin
            ring_we = (32'(clr_cnt_ff) < PRE_DEPTH);
            ring_wa = PRE_AW'(clr_cnt_ff);
            ring_wd = 32'd0;
         end
         S_RUN: begin
            ring_we = req_accept && (req_data.kind == KIND_SAMPLE) && ring_hit;
         end
         default: ;
      endcase
   end

   assign ring_re = (state_ff == S_COPY) && (copy_rd_ff != copy_n_ff);

   lctc_ram #(
      .WIDTH (32),
      .DEPTH (CAPTURE_DEPTH)
   ) u_capture_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (cap_wa),
      .wr_data (cap_wd),
      .rd_en   (cap_re),
      .rd_addr (cap_ra),
      .rd_data (cap_rd)
   );

   lctc_ram #(
      .WIDTH (32),
      .DEPTH (PRE_DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wd),
      .rd_en   (ring_re),
      .rd_addr (copy_ra_ff),
      .rd_data (ring_rd)
   );

   `ASSERT_IMPLY(a_wp_bound, clock, reset, 1'b1, wp_ff <= WP_W'(CAPTURE_DEPTH), "fill position beyond capture depth")
   `ASSERT_NEXT(a_restart_copy, clock, reset, req_accept && restart && (n_sat != 6'd0), (state_ff == S_COPY) && req_stall, "restart with pre-trigger points did not block input")
   `ASSERT_IMPLY(a_copy_count, clock, reset, state_ff == S_COPY, copy_rd_ff <= copy_n_ff, "ring copy ran past its count")
   `ASSERT_IMPLY(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !rsp_valid_ff && !copy_wv_ff, "activity during clearing pass")

endmodule
